// File: rtl/sha1kd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sha1kd_pkg - shared types and constants for the SHA-1 key derivation block
// Holds the fixed message words, the SHA-1 initial value and round constants,
// and the control struct passed from the sequencer to the datapath modules.
// ----------------------------------------------------------------------------
package sha1kd_pkg;

	localparam int ROUNDS   = 80;
	localparam int RND_W    = $clog2(ROUNDS);
	localparam int WORD_W   = 32;
	localparam int WIN      = 16;
	localparam int UID_W    = 56;
	localparam int KEY_W    = 48;

	// fixed words of the padded block; words 4 and 5 carry the identifier
	localparam logic [WORD_W-1:0] MSG_W0  = 32'h0A14FD05;
	localparam logic [WORD_W-1:0] MSG_W1  = 32'h07FF4BCD;
	localparam logic [WORD_W-1:0] MSG_W2  = 32'h026BA83F;
	localparam logic [WORD_W-1:0] MSG_W3  = 32'h0A3B89A9;
	localparam logic [7:0]        MSG_B23 = 8'h28;
	localparam logic [WORD_W-1:0] MSG_W6  = 32'h63292044;
	localparam logic [WORD_W-1:0] MSG_W7  = 32'h69736E65;
	localparam logic [WORD_W-1:0] MSG_W8  = 32'h79203230;
	localparam logic [WORD_W-1:0] MSG_W9  = 32'h31338000;
	localparam logic [WORD_W-1:0] MSG_W15 = 32'h00000130;

	localparam logic [WORD_W-1:0] IV0 = 32'h67452301;
	localparam logic [WORD_W-1:0] IV1 = 32'hEFCDAB89;
	localparam logic [WORD_W-1:0] IV2 = 32'h98BADCFE;
	localparam logic [WORD_W-1:0] IV3 = 32'h10325476;
	localparam logic [WORD_W-1:0] IV4 = 32'hC3D2E1F0;

	localparam logic [WORD_W-1:0] K0 = 32'h5A827999;
	localparam logic [WORD_W-1:0] K1 = 32'h6ED9EBA1;
	localparam logic [WORD_W-1:0] K2 = 32'h8F1BBCDC;
	localparam logic [WORD_W-1:0] K3 = 32'hCA62C1D6;

	// sequencer to datapath control
	typedef struct packed {
		logic load;   // start of a new block
		logic step;   // advance one round
	} sha1kd_ctrl_t;

endpackage : sha1kd_pkg
`default_nettype wire

// File: rtl/sha1kd_sched.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sha1kd_sched - SHA-1 message schedule
// Sixteen-word sliding window; word 0 feeds the current round and a new
// expanded word enters at the top on every step.
// ----------------------------------------------------------------------------
module sha1kd_sched
	import sha1kd_pkg::*;
(
	input  wire                 clk,
	input  sha1kd_ctrl_t        ctrl,
	input  wire [UID_W-1:0]     uid,
	output logic [WORD_W-1:0]   w
);

	logic [WORD_W-1:0] win_q [WIN];
	logic [WORD_W-1:0] mix;
	logic [WORD_W-1:0] w_new;

	assign mix   = win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0];
	assign w_new = {mix[WORD_W-2:0], mix[WORD_W-1]};
	assign w     = win_q[0];

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			win_q[0]  <= MSG_W0;
			win_q[1]  <= MSG_W1;
			win_q[2]  <= MSG_W2;
			win_q[3]  <= MSG_W3;
			win_q[4]  <= uid[55:24];
			win_q[5]  <= {uid[23:0], MSG_B23};
			win_q[6]  <= MSG_W6;
			win_q[7]  <= MSG_W7;
			win_q[8]  <= MSG_W8;
			win_q[9]  <= MSG_W9;
			win_q[10] <= '0;
			win_q[11] <= '0;
			win_q[12] <= '0;
			win_q[13] <= '0;
			win_q[14] <= '0;
			win_q[15] <= MSG_W15;
		end else if (ctrl.step) begin
			for (int i = 0; i < WIN - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[WIN-1] <= w_new;
		end
	end

endmodule : sha1kd_sched
`default_nettype wire

// File: rtl/sha1kd_round.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sha1kd_round - SHA-1 compression round unit
// Working registers a..e and one shared round datapath, reused for all
// eighty rounds; final feed-forward of the first two digest words.
// ----------------------------------------------------------------------------
module sha1kd_round
	import sha1kd_pkg::*;
(
	input  wire                 clk,
	input  sha1kd_ctrl_t        ctrl,
	input  wire [RND_W-1:0]     rnd,
	input  wire [WORD_W-1:0]    w,
	output logic [WORD_W-1:0]   h0,
	output logic [WORD_W-1:0]   h1
);

	logic [WORD_W-1:0] a_q, b_q, c_q, d_q, e_q;
	logic [WORD_W-1:0] f, k, t;

	always_comb begin
		priority if (rnd < RND_W'(20)) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = K0;
		end else if (rnd < RND_W'(40)) begin
			f = b_q ^ c_q ^ d_q;
			k = K1;
		end else if (rnd < RND_W'(60)) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = K2;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = K3;
		end
	end

	assign t = {a_q[WORD_W-6:0], a_q[WORD_W-1:WORD_W-5]} + f + e_q + k + w;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			a_q <= IV0;
			b_q <= IV1;
			c_q <= IV2;
			d_q <= IV3;
			e_q <= IV4;
		end else if (ctrl.step) begin
			a_q <= t;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[WORD_W-1:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
	end

	assign h0 = a_q + IV0;
	assign h1 = b_q + IV1;

endmodule : sha1kd_round
`default_nettype wire

// File: rtl/uid_keyed_sha1_key_derivation.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uid_keyed_sha1_key_derivation - card key derivation by SHA-1 over the UID
// Places a seven-byte UID into a fixed seed message, hashes it with SHA-1 and
// returns six digest bytes as a sector key.
// ----------------------------------------------------------------------------
// A seven-byte UID transfer (first byte in bits 55:48) starts one SHA-1 block
// computation over the fixed 38-byte seed with the UID at byte offset 16; the
// result transfer is a 48-bit key built from digest bytes 3,2,1,0,7,6, first
// key byte in bits 47:40. One compression round runs per clock on a single
// shared round unit fed by a sixteen-word schedule window. The load happens
// at the accepting edge, then 80 rounds run, then the digest feed-forward is
// captured in the output register; the next input transfer can follow once
// the sequencer is back in idle, so items do not overlap. in_stall stays
// high from the input transfer until the result has been placed in the
// output register; a held result only delays the next item if it is still
// untaken when that item finishes. No state carries between items.
// ----------------------------------------------------------------------------
module uid_keyed_sha1_key_derivation
	import sha1kd_pkg::*;
(
	input  wire                 clk,
	input  wire                 arst_n,
	// input channel
	input  wire                 in_valid,
	output logic                in_stall,
	input  wire [UID_W-1:0]     uid,
	// result channel
	output logic                out_valid,
	input  wire                 out_stall,
	output logic [KEY_W-1:0]    derived_key
);

	// sequencer states
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0]         state_q;
	logic [RND_W-1:0]   rnd_q;
	logic               out_valid_q;
	logic [KEY_W-1:0]   key_q;

	sha1kd_ctrl_t       ctrl;
	logic               in_xfer;
	logic               out_free;
	logic [WORD_W-1:0]  w;
	logic [WORD_W-1:0]  h0, h1;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	// output register can take a new key when empty or being drained now
	assign out_free  = !out_valid_q || !out_stall;

	assign ctrl.load = in_xfer;
	assign ctrl.step = (state_q == ST_RUN);

	sha1kd_sched u_sched (
		.clk  (clk),
		.ctrl (ctrl),
		.uid  (uid),
		.w    (w)
	);

	sha1kd_round u_round (
		.clk  (clk),
		.ctrl (ctrl),
		.rnd  (rnd_q),
		.w    (w),
		.h0   (h0),
		.h1   (h1)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rnd_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_RUN;
						rnd_q   <= '0;
					end
				end
				ST_RUN: begin
					if (rnd_q == RND_W'(ROUNDS - 1)) begin
						state_q <= ST_FIN;
					end else begin
						rnd_q <= rnd_q + 1'b1;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result register: valid flag under reset, key payload without
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_FIN) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// key = digest bytes 3,2,1,0 (H0 low to high) then 7,6 (H1 low two)
	always_ff @(posedge clk) begin
		if ((state_q == ST_FIN) && out_free) begin
			key_q <= {h0[7:0], h0[15:8], h0[23:16], h0[31:24], h1[7:0], h1[15:8]};
		end
	end

	assign out_valid   = out_valid_q;
	assign derived_key = key_q;

endmodule : uid_keyed_sha1_key_derivation
`default_nettype wire
